/* src/wgm_pkg.sv */
// ---------------------------------------------------------------------------
// wgm_pkg: shared types and constants for the wildcard glob matcher
// Pattern store size, request modes, special pattern bytes, cell control.
// ---------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_TEXT   = 2'd1,
    MODE_END    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  // broadcast to every cell
  typedef struct packed {
    logic       step;     // text byte taken this cycle
    logic       restart;  // back to start position only
    logic [7:0] sym;      // pattern or text byte
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/wgm_if.sv */
// ---------------------------------------------------------------------------
// wgm_in_if / wgm_out_if: request and result channels
// Valid/ready handshake with the matcher payload fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

/* src/wgm_cell.sv */
// ---------------------------------------------------------------------------
// wgm_cell: one pattern position of the matcher
// Holds pattern byte p and the active flag of position p+1.
// ---------------------------------------------------------------------------
`default_nettype none

module wgm_cell
  import wgm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_ctl_t ctl_i,
  input  wire logic      wr_en_i,   // load pattern byte into this cell
  input  wire logic      vld_i,     // cell lies inside the pattern
  input  wire logic      closed_i,  // closed active flag of position p
  input  wire logic      keep_i,    // star self-loop from the next cell
  output logic           keep_o,    // star self-loop back to position p
  output logic           star_o,    // live star, for the closure
  output logic           act_o      // raw active flag of position p+1
);

  logic [7:0] byte_q;
  logic       act_q, act_d;
  logic       hit, adv;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      byte_q <= ctl_i.sym;
    end
  end

  assign star_o = vld_i && (byte_q == STAR_BYTE);
  assign hit    = (byte_q == ctl_i.sym) || ((byte_q == ANY_BYTE) && (ctl_i.sym != DOT_BYTE));
  assign adv    = closed_i && vld_i && !star_o && hit;
  assign keep_o = closed_i && star_o;

  always_comb begin
    act_d = act_q;
    if (ctl_i.restart) begin
      act_d = 1'b0;
    end else if (ctl_i.step) begin
      act_d = adv || keep_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  assign act_o = act_q;

endmodule

`default_nettype wire

/* src/wildcard_glob_matcher.sv */
// ---------------------------------------------------------------------------
// wildcard_glob_matcher: streaming glob matcher over a row of pattern cells
// Pattern bytes load into cells; text bytes step a bit-parallel NFA.
// ---------------------------------------------------------------------------
// Result: an end-of-text request shows its result in the cycle after acceptance.
// Throughput: one request per cycle in all modes unless stalled; text bytes step the cells.
// Result is held in an output register; requests keep flowing while it waits
// unless the result register is full and stalled.
// Reset: pattern empty, overflow clear, only the start position active.
`default_nettype none

module wildcard_glob_matcher
  import wgm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wgm_in_if.sink    in_i,
  wgm_out_if.source out_o
);

  localparam int unsigned N = MAX_PATTERN;

  // request decode
  logic  acc;
  mode_e mode;
  assign mode = mode_e'(in_i.mode);
  assign acc  = in_i.valid && in_i.ready;

  // pattern length and overflow
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             full;
  assign full = (len_q == LEN_W'(N));

  // position 0 lives here, positions 1..N in the cells
  logic pos0_q, pos0_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic matched_q, matched_d;
  logic ovfo_q;

  cell_ctl_t ctl;
  logic [N-1:0] wr_en, vld, star, act_c;
  logic [N:0]   keep;   // keep[p] targets position p; keep[N] unused tail
  logic [N:0]   act_s, star_m, gen, carry, closed;

  assign in_i.ready = !out_valid_q || out_o.ready;

  always_comb begin
    ctl.sym     = in_i.symbol;
    ctl.step    = acc && (mode == MODE_TEXT);
    ctl.restart = acc && (mode != MODE_TEXT);
  end

  for (genvar p = 0; p < N; p++) begin : g_row
    assign wr_en[p] = acc && (mode == MODE_APPEND) && (len_q == LEN_W'(p));
    assign vld[p]   = LEN_W'(p) < len_q;

    wgm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .wr_en_i  (wr_en[p]),
      .vld_i    (vld[p]),
      .closed_i (closed[p]),
      .keep_i   (keep[p+1]),
      .keep_o   (keep[p]),
      .star_o   (star[p]),
      .act_o    (act_c[p])
    );
  end

  assign keep[N] = 1'b0;

  // Star closure as a carry chain: a live star propagates an active flag
  // one position up, and runs of stars ripple like a carry.
  assign act_s  = {act_c, pos0_q};
  assign star_m = {1'b0, star};
  assign gen    = act_s & star_m;
  assign carry  = (gen + star_m) ^ gen ^ star_m;
  assign closed = act_s | carry;

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    pos0_d      = pos0_q;
    out_valid_d = out_valid_q && !out_o.ready;
    matched_d   = !ovf_q && closed[len_q];
    if (acc) begin
      unique case (mode)
        MODE_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LEN_W'(1);
          end
          pos0_d = 1'b1;
        end
        MODE_TEXT: begin
          pos0_d = keep[0];
        end
        MODE_END: begin
          out_valid_d = 1'b1;
          pos0_d      = 1'b1;
        end
        MODE_CLEAR: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          pos0_d = 1'b1;
        end
        default: begin
          pos0_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      pos0_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      pos0_q      <= pos0_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on end of text
  always_ff @(posedge clk_i) begin
    if (acc && (mode == MODE_END)) begin
      matched_q <= matched_d;
      ovfo_q    <= ovf_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = ovfo_q;

  // length never runs past the store
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(N))
    else $error("pattern length beyond store");

  // overflow only sets on an append into a full store
  a_ovf_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(acc && (mode == MODE_APPEND) && full))
    else $error("overflow set without a full append");

  // an accepted end of text always yields a result next cycle
  a_end_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode == MODE_END)) |=> out_valid_q)
    else $error("end of text gave no result");

  // overflow forces no match
  a_ovf_nomatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovfo_q) |-> !matched_q)
    else $error("match reported with overflow");

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for wildcard_glob_matcher
// Directed table of requests, then random pattern/text sessions. Every
// end-of-text result is checked against a cycle-free glob NFA predictor or a typed-in value.
// ---------------------------------------------------------------------------

module tb
  import wgm_pkg::*;
();

  localparam int ITEMS     = 1700;  // random requests to send
  localparam int CALM_TAIL = 200;   // last requests go out with no idling
  localparam int WD_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int NROWS     = 27;

  typedef struct packed {
    logic matched;
    logic overflow;
  } glob_res_t;

  typedef struct {
    mode_e      mode;
    logic [7:0] sym;
    int         reps;
    bit         fixed;   // expected result typed in below
    glob_res_t  want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  wgm_in_if  req_if ();
  wgm_out_if res_if ();

  wildcard_glob_matcher uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // -------------------------------------------------------------------------
  // Glob predictor: own copy of the pattern cells and the active-position set.
  // Bit p of live_pos set means the text so far matches the first p pattern
  // bytes; stars are closed over only when the set is consumed.
  // -------------------------------------------------------------------------
  logic [7:0]           pat_mem [MAX_PATTERN];
  int unsigned          pat_len;
  logic [MAX_PATTERN:0] live_pos;
  bit                   pat_ovf;

  // a star can match an empty run, so an active star also activates the
  // position after it; ascending order lets runs of stars chain through
  function automatic logic [MAX_PATTERN:0] star_closure(input logic [MAX_PATTERN:0] s);
    for (int p = 0; p < pat_len; p++) begin
      if (s[p] && pat_mem[p] == STAR_BYTE) s[p+1] = 1'b1;
    end
    return s;
  endfunction

  // applies one request; returns 1 when it yields a result
  function automatic bit glob_step(input mode_e m, input logic [7:0] c,
                                   output glob_res_t r);
    logic [MAX_PATTERN:0] cur;
    logic [MAX_PATTERN:0] nxt;
    bit                   has;
    r   = '0;
    has = 1'b0;
    case (m)
      MODE_APPEND: begin
        // byte past the store is dropped, flag stays until clear
        if (pat_len < MAX_PATTERN) begin
          pat_mem[pat_len] = c;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        live_pos = 1;
      end
      MODE_TEXT: begin
        cur = star_closure(live_pos);
        nxt = '0;
        for (int p = 0; p < pat_len; p++) begin
          if (cur[p]) begin
            if (pat_mem[p] == STAR_BYTE) nxt[p] = 1'b1;
            else if (pat_mem[p] == c || (pat_mem[p] == ANY_BYTE && c != DOT_BYTE))
              nxt[p+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      MODE_END: begin
        cur        = star_closure(live_pos);
        r.matched  = !pat_ovf && cur[pat_len];
        r.overflow = pat_ovf;
        live_pos   = 1;
        has        = 1'b1;
      end
      default: begin
        pat_len  = 0;
        pat_ovf  = 1'b0;
        live_pos = 1;
      end
    endcase
    return has;
  endfunction

  // -------------------------------------------------------------------------
  // Transfer monitor: predicts on each accepted request, checks each accepted
  // result against the oldest waiting expectation, and runs the watchdog.
  // -------------------------------------------------------------------------
  glob_res_t verdict_q [$];
  bit        pin_fixed;     // current request carries a typed-in expectation
  glob_res_t pin_want;
  int        fails;
  int        n_results, n_matches, n_ovf_results;
  int        quiet_cycles;

  always @(posedge clk) begin : xfer_mon
    glob_res_t pred;
    glob_res_t got;
    glob_res_t want;
    bit        busy;
    busy = 1'b0;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        busy = 1'b1;
        if (glob_step(mode_e'(req_if.mode), req_if.symbol, pred)) begin
          if (pin_fixed) pred = pin_want;
          verdict_q.push_back(pred);
        end
      end
      if (res_if.valid && res_if.ready) begin
        busy          = 1'b1;
        got.matched   = res_if.matched;
        got.overflow  = res_if.pattern_overflow;
        n_results++;
        if (got.matched) n_matches++;
        if (got.overflow) n_ovf_results++;
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: matched %0d pattern_overflow %0d",
                 got.matched, got.overflow);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, got.matched);
            fails++;
          end
          if (got.overflow !== want.overflow) begin
            $error("pattern_overflow: expected %0d, actual %0d",
                   want.overflow, got.overflow);
            fails++;
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WD_LIMIT);
        $display("wildcard_glob_matcher: mismatch");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result side back-pressure: random stall bursts, none once the run enters
  // its calm tail.
  // -------------------------------------------------------------------------
  bit calm;
  int stall_left;

  always @(negedge clk) begin
    if (calm) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Request driver. Called at a falling edge; returns at the falling edge
  // after the request was taken, with valid still high.
  // -------------------------------------------------------------------------
  int sent;

  task automatic send_req(input mode_e m, input logic [7:0] s,
                          input bit fixed = 1'b0, input glob_res_t want = '0);
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    pin_fixed     = fixed;
    pin_want      = want;
    req_if.valid  <= 1'b1;
    req_if.mode   <= m;
    req_if.symbol <= s;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [7:0] rand_pat_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return STAR_BYTE;
      3, 4:    return ANY_BYTE;
      5:       return DOT_BYTE;
      6:       return 8'h61;
      7:       return 8'h62;
      8:       return 8'h63;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_text_byte();
    case ($urandom_range(0, 4))
      0:       return DOT_BYTE;
      1:       return 8'h61;
      2:       return 8'h62;
      3:       return 8'h63;
      default: return 8'($urandom);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Directed plan: extremes of the symbol, every mode, empty pattern, stars
  // over dots, '?' refusing a dot, text shorter than a starred segment, full
  // store, overflow and its recovery, append discarding text in progress.
  // -------------------------------------------------------------------------
  plan_row_t plan [NROWS];
  logic [7:0] pat_shadow [$];  // bench-side copy of the pattern being built
  logic [7:0] words [$];

  initial begin
    int episodes;
    logic [7:0] b;
    plan = '{
      '{MODE_END,    8'h00,     1,  1'b1, '{1'b1, 1'b0}},  // empty vs empty
      '{MODE_TEXT,   8'hFF,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_END,    8'h00,     1,  1'b1, '{1'b0, 1'b0}},  // empty vs one byte
      '{MODE_APPEND, STAR_BYTE, 2,  1'b0, '{1'b0, 1'b0}},  // star run acts as one
      '{MODE_APPEND, ANY_BYTE,  1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_APPEND, 8'h00,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,   DOT_BYTE,  2,  1'b0, '{1'b0, 1'b0}},  // star eats dots
      '{MODE_TEXT,   8'h78,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,   8'h00,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_END,    8'hFF,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,   DOT_BYTE,  1,  1'b0, '{1'b0, 1'b0}},  // '?' on a dot
      '{MODE_TEXT,   8'h00,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_END,    8'h00,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_TEXT,   8'h00,     1,  1'b0, '{1'b0, 1'b0}},  // too short
      '{MODE_END,    8'h00,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_CLEAR,  8'hFF,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_END,    8'h00,     1,  1'b1, '{1'b1, 1'b0}},
      '{MODE_APPEND, 8'h61,     32, 1'b0, '{1'b0, 1'b0}},  // store exactly full
      '{MODE_TEXT,   8'h61,     32, 1'b0, '{1'b0, 1'b0}},
      '{MODE_END,    8'h00,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_APPEND, 8'hFF,     1,  1'b0, '{1'b0, 1'b0}},  // one past the store
      '{MODE_TEXT,   8'h61,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_END,    8'h00,     1,  1'b1, '{1'b0, 1'b1}},
      '{MODE_CLEAR,  8'h00,     1,  1'b0, '{1'b0, 1'b0}},  // overflow released
      '{MODE_TEXT,   8'h7A,     1,  1'b0, '{1'b0, 1'b0}},
      '{MODE_APPEND, DOT_BYTE,  1,  1'b0, '{1'b0, 1'b0}},  // drops the 'z'
      '{MODE_TEXT,   DOT_BYTE,  1,  1'b0, '{1'b0, 1'b0}}
    };

    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.mode   = MODE_CLEAR;
    req_if.symbol = 8'h00;
    res_if.ready  = 1'b0;
    calm          = 1'b0;
    pin_fixed     = 1'b0;
    pin_want      = '0;
    fails         = 0;
    sent          = 0;
    stall_left    = 0;
    quiet_cycles  = 0;
    n_results     = 0;
    n_matches     = 0;
    n_ovf_results = 0;
    pat_len       = 0;
    pat_ovf       = 1'b0;
    live_pos      = 1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      repeat (plan[i].reps) send_req(plan[i].mode, plan[i].sym, plan[i].fixed, plan[i].want);
    end
    send_req(MODE_END, 8'h00);
    sent = 0;

    // Random sessions: mostly clear + fresh pattern, then a few texts built to
    // follow the pattern with occasional corruption; a little raw noise.
    episodes = 0;
    pat_shadow.delete();
    send_req(MODE_CLEAR, 8'($urandom));
    sent = 0;
    while (sent < ITEMS) begin
      episodes++;
      if (sent >= ITEMS - CALM_TAIL) calm = 1'b1;

      // hold off once until the result side has drained completely
      if (episodes == 25) begin
        req_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end

      if ($urandom_range(0, 9) < 8) begin
        int plen;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 7);
        send_req(MODE_CLEAR, 8'($urandom));
        pat_shadow.delete();
        repeat (plen) begin
          b = rand_pat_byte();
          pat_shadow.push_back(b);
          send_req(MODE_APPEND, b);
        end
      end else begin
        repeat ($urandom_range(1, 2)) begin
          b = rand_pat_byte();
          pat_shadow.push_back(b);
          send_req(MODE_APPEND, b);
        end
      end

      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray request of any mode
          mode_e m;
          m = mode_e'($urandom_range(0, 3));
          b = 8'($urandom);
          if (m == MODE_APPEND) pat_shadow.push_back(b);
          if (m == MODE_CLEAR) pat_shadow.delete();
          send_req(m, b);
        end else begin
          words.delete();
          foreach (pat_shadow[k]) begin
            if (pat_shadow[k] == STAR_BYTE) begin
              repeat ($urandom_range(0, 3)) words.push_back(rand_text_byte());
            end else if (pat_shadow[k] == ANY_BYTE) begin
              b = rand_text_byte();
              words.push_back(b == DOT_BYTE ? 8'h71 : b);
            end else begin
              words.push_back(pat_shadow[k]);
            end
          end
          // corrupt about a quarter: overwrite, drop or insert one byte
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
              0: if (words.size() > 0)
                   words[$urandom_range(0, words.size() - 1)] = rand_text_byte();
              1: if (words.size() > 0) words.delete($urandom_range(0, words.size() - 1));
              default: words.insert($urandom_range(0, words.size()), rand_text_byte());
            endcase
          end
          foreach (words[k]) send_req(MODE_TEXT, words[k]);
          send_req(MODE_END, 8'($urandom));
        end
      end
    end
    req_if.valid <= 1'b0;

    // drain, then give the registered result path time to show anything stray
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d random requests in %0d pattern sessions plus the directed plan",
             sent, episodes);
    $display("results checked: %0d, of them %0d matches and %0d with overflow set",
             n_results, n_matches, n_ovf_results);
    if (fails == 0) begin
      $display("wildcard_glob_matcher: match");
    end else begin
      $display("wildcard_glob_matcher: mismatch");
    end
    $finish;
  end

endmodule
